// ----- sv/clt_pkg.sv -----
// Package for the clap level trigger: widths, reset values and register indexes.
// Used by clap_level_trigger_unit; depends on nothing else.
`timescale 1ns / 1ps

package clt_pkg;

  // Samples summed per level block (a power of two)
  localparam int unsigned BLOCK    = 2048;
  localparam int unsigned BLOCK_LG = $clog2(BLOCK);

  // Field widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned GAIN_W   = 4;
  localparam int unsigned LEVEL_W  = 19;
  localparam int unsigned THR_W    = 20;
  localparam int unsigned TICK_W   = 16;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned CNT_W    = BLOCK_LG;
  localparam int unsigned SUM_W    = SAMPLE_W + BLOCK_LG;
  localparam int unsigned PROD_W   = SUM_W + GAIN_W;

  // Stream and configuration port widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  // Register reset values
  localparam logic [GAIN_W-1:0] GAIN_RST       = GAIN_W'(5);
  localparam logic [THR_W-1:0]  INIT_THR_RST   = THR_W'(5000);
  localparam logic [THR_W-1:0]  THR_FLOOR_RST  = THR_W'(1500);
  localparam logic [TICK_W-1:0] CAL_TICKS_RST  = TICK_W'(180);
  localparam logic [STEP_W-1:0] SLOW_STEP_RST  = STEP_W'(50);
  localparam logic [STEP_W-1:0] FAST_STEP_RST  = STEP_W'(500);
  localparam logic [THR_W-1:0]  THR_MAX        = {THR_W{1'b1}};

  // Input item kinds carried on tuser
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN      = 3'd0,
    CFG_INIT_THR  = 3'd1,
    CFG_THR_FLOOR = 3'd2,
    CFG_CAL_TICKS = 3'd3,
    CFG_SLOW_STEP = 3'd4,
    CFG_FAST_STEP = 3'd5
  } cfg_idx_e;

endpackage

// ----- sv/clap_level_trigger_unit.sv -----
// Clap level trigger top level: block level meter, threshold compare,
// auto calibration and manual threshold steps. Depends on clt_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_axis_*): tuser is the item kind, 0 = audio sample,
//   1 = frame tick. tdata carries the sample and the key flags of a tick.
//   Every accepted item yields exactly one result on the output stream
//   (m_axis_*): jump, level, threshold, calibrating and level_updated,
//   all as they stand after the item.
//   Latency: the result is valid the cycle after the input transfer.
//   Throughput: one item per cycle; the whole update of level meter and
//   threshold state is one combinational pass into the result register.
//   Stall: the result register holds while m_axis_tready is low, and the
//   input is taken again in the same cycle the held result is taken.
//   Reset (rst_ni low): registers return to their defaults, the level
//   accumulator and level clear, the threshold loads 5000, calibration is
//   off and the output stream is empty. Writes to initial_threshold are
//   not stored: reset loads a constant, and the live threshold never moves.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i;
//   write only while no item is in flight.
module clap_level_trigger_unit
  import clt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [15:0] sample, [16] key_up, [17] key_dn, [18] fast,
  // [19] start_calibration, [23:20] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] command
  input  logic                  s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] jump, [19:1] level, [39:20] threshold, [40] calibrating,
  // [41] level_updated, [47:42] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  // Configuration registers
  logic [GAIN_W-1:0] gain_q;
  logic [THR_W-1:0]  thr_floor_q;
  logic [TICK_W-1:0] cal_ticks_q;
  logic [STEP_W-1:0] slow_step_q;
  logic [STEP_W-1:0] fast_step_q;

  // Block state
  logic [SUM_W-1:0]   abs_sum_q, abs_sum_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEVEL_W-1:0] level_q, level_d;
  logic [THR_W-1:0]   thr_q, thr_d;
  logic               cal_q, cal_d;
  logic [LEVEL_W-1:0] peak_q, peak_d;
  logic [TICK_W-1:0]  ticks_q, ticks_d;

  // Result register
  logic                  out_vld_q;
  logic [OUT_DATA_W-1:0] out_data_q, out_data_d;

  // Input fields
  logic                is_tick;
  logic [SAMPLE_W-1:0] raw;
  logic                key_up, key_dn, fast, start_cal;
  logic                in_xfer;

  // Datapath intermediates
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]    sum_acc;
  logic [PROD_W-1:0]   prod;
  logic                blk_end;
  logic [LEVEL_W-1:0]  peak_max;
  logic [TICK_W:0]     ticks_inc;
  logic [THR_W+1:0]    cal_thr;
  logic [THR_W-1:0]    cal_thr_sat;
  logic [STEP_W-1:0]   step;
  logic [THR_W:0]      thr_up_sum;
  logic [THR_W-1:0]    thr_up;
  logic                jump;
  logic                updated;

  assign is_tick   = (s_axis_tuser == CMD_TICK);
  assign raw       = s_axis_tdata[SAMPLE_W-1:0];
  assign key_up    = s_axis_tdata[SAMPLE_W];
  assign key_dn    = s_axis_tdata[SAMPLE_W+1];
  assign fast      = s_axis_tdata[SAMPLE_W+2];
  assign start_cal = s_axis_tdata[SAMPLE_W+3];

  // Take a new item whenever the result register is empty or being drained
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Level meter: absolute value, accumulate, scale at block end
  assign mag     = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
  assign sum_acc = abs_sum_q + {{(SUM_W-SAMPLE_W){1'b0}}, mag};
  assign prod    = {{GAIN_W{1'b0}}, sum_acc} * {{SUM_W{1'b0}}, gain_q};
  assign blk_end = (cnt_q == CNT_W'(BLOCK - 1));

  // Calibration helpers
  assign peak_max    = (level_q > peak_q) ? level_q : peak_q;
  assign ticks_inc   = {1'b0, ticks_q} + (TICK_W+1)'(1);
  assign cal_thr     = ({{(THR_W-LEVEL_W+2){1'b0}}, peak_max} * (THR_W+2)'(3)) >> 1;
  assign cal_thr_sat = (cal_thr < {2'b00, thr_floor_q}) ? thr_floor_q : cal_thr[THR_W-1:0];

  // Manual adjustment helpers
  assign step       = fast ? fast_step_q : slow_step_q;
  assign thr_up_sum = {1'b0, thr_q} + {{(THR_W-STEP_W+1){1'b0}}, step};
  assign thr_up     = (key_up && thr_up_sum > {1'b0, THR_MAX}) ? THR_MAX :
                      key_up ? thr_up_sum[THR_W-1:0] : thr_q;

  // Next state for one item
  always_comb begin
    abs_sum_d = abs_sum_q;
    cnt_d     = cnt_q;
    level_d   = level_q;
    thr_d     = thr_q;
    cal_d     = cal_q;
    peak_d    = peak_q;
    ticks_d   = ticks_q;
    updated   = 1'b0;
    if (!is_tick) begin
      // Sample: accumulate, close the block on its last sample
      if (blk_end) begin
        level_d   = prod[BLOCK_LG +: LEVEL_W];
        abs_sum_d = '0;
        cnt_d     = '0;
        updated   = 1'b1;
      end else begin
        abs_sum_d = sum_acc;
        cnt_d     = cnt_q + CNT_W'(1);
      end
    end else if (cal_q) begin
      // Calibrating tick: track peak, end once the count is exceeded
      peak_d = peak_max;
      if (ticks_inc > {1'b0, cal_ticks_q}) begin
        cal_d = 1'b0;
        thr_d = cal_thr_sat;
      end else begin
        ticks_d = ticks_inc[TICK_W-1:0];
      end
    end else begin
      // Normal tick: up first, then down, then maybe start calibration
      thr_d = thr_up;
      if (key_dn && thr_up > {{(THR_W-STEP_W){1'b0}}, step}) begin
        thr_d = thr_up - {{(THR_W-STEP_W){1'b0}}, step};
      end
      if (start_cal) begin
        cal_d   = 1'b1;
        peak_d  = '0;
        ticks_d = '0;
      end
    end
  end

  // Pack the result from the updated state
  assign jump = !cal_d && ({1'b0, level_d} > thr_d);
  assign out_data_d = {{(OUT_DATA_W-THR_W-LEVEL_W-3){1'b0}},
                       updated, cal_d, thr_d, level_d, jump};

  // State and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q      <= GAIN_RST;
      thr_floor_q <= THR_FLOOR_RST;
      cal_ticks_q <= CAL_TICKS_RST;
      slow_step_q <= SLOW_STEP_RST;
      fast_step_q <= FAST_STEP_RST;
      abs_sum_q   <= '0;
      cnt_q       <= '0;
      level_q     <= '0;
      thr_q       <= INIT_THR_RST;
      cal_q       <= 1'b0;
      peak_q      <= '0;
      ticks_q     <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_GAIN:      gain_q      <= cfg_data_i[GAIN_W-1:0];
          // Reset loads the threshold from a constant, so this value is not stored
          CFG_INIT_THR:  ;
          CFG_THR_FLOOR: thr_floor_q <= cfg_data_i[THR_W-1:0];
          CFG_CAL_TICKS: cal_ticks_q <= cfg_data_i[TICK_W-1:0];
          CFG_SLOW_STEP: slow_step_q <= cfg_data_i[STEP_W-1:0];
          CFG_FAST_STEP: fast_step_q <= cfg_data_i[STEP_W-1:0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        abs_sum_q <= abs_sum_d;
        cnt_q     <= cnt_d;
        level_q   <= level_d;
        thr_q     <= thr_d;
        cal_q     <= cal_d;
        peak_q    <= peak_d;
        ticks_q   <= ticks_d;
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Result payload: load on each input transfer, hold while stalled
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule
